@@ rtl/core/ebp_pkg.sv @@
// Shared constants, types and the control store of the extent bisection partitioner.
package ebp_pkg;

  localparam int MaxPartsDef  = 64;
  localparam int CoordBitsDef = 16;
  localparam int CntInW       = 7;
  localparam int PidxW        = 6;

  typedef logic [1:0] ebp_axis_t;
  localparam ebp_axis_t AX_I = 2'd0;
  localparam ebp_axis_t AX_J = 2'd1;
  localparam ebp_axis_t AX_K = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_POP,
    S_LEN,
    S_AXIS,
    S_WR_OLD,
    S_WR_NEW,
    S_E_RD,
    S_E_LD
  } ebp_step_e;

  typedef enum logic [1:0] {
    WT_NONE,
    WT_REQ,
    WT_SLOT
  } ebp_wait_e;

  typedef enum logic [1:0] {
    JC_ALWAYS,
    JC_DONE,
    JC_LAST
  } ebp_jump_e;

  typedef struct packed {
    logic      in_rdy;
    logic      ld_in;
    logic      q_rd;
    logic      rd_pop;
    logic      rd_emit;
    logic      len_ld;
    logic      axis_ld;
    logic      wr_old;
    logic      wr_new;
    logic      out_ld;
    ebp_wait_e wt;
    ebp_jump_e jc;
    ebp_step_e tgt;
    ebp_step_e nxt;
  } ebp_ucode_t;

  function automatic ebp_ucode_t ebp_ucode(input ebp_step_e s);
    ebp_ucode_t w;
    w     = '0;
    w.wt  = WT_NONE;
    w.jc  = JC_ALWAYS;
    w.tgt = S_IDLE;
    w.nxt = S_IDLE;
    unique case (s)
      S_IDLE: begin
        w.in_rdy = 1'b1;
        w.ld_in  = 1'b1;
        w.wt     = WT_REQ;
        w.tgt    = S_CHECK;
      end
      S_CHECK: begin
        w.q_rd = 1'b1;
        w.jc   = JC_DONE;
        w.tgt  = S_E_RD;
        w.nxt  = S_POP;
      end
      S_POP: begin
        w.rd_pop = 1'b1;
        w.tgt    = S_LEN;
      end
      S_LEN: begin
        w.len_ld = 1'b1;
        w.tgt    = S_AXIS;
      end
      S_AXIS: begin
        w.axis_ld = 1'b1;
        w.tgt     = S_WR_OLD;
      end
      S_WR_OLD: begin
        w.wr_old = 1'b1;
        w.tgt    = S_WR_NEW;
      end
      S_WR_NEW: begin
        w.wr_new = 1'b1;
        w.tgt    = S_CHECK;
      end
      S_E_RD: begin
        w.rd_emit = 1'b1;
        w.tgt     = S_E_LD;
      end
      S_E_LD: begin
        w.out_ld = 1'b1;
        w.wt     = WT_SLOT;
        w.jc     = JC_LAST;
        w.tgt    = S_IDLE;
        w.nxt    = S_E_RD;
      end
      default: begin
        w.tgt = S_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

@@ rtl/core/ebp_req_if.sv @@
// Request channel: global extent and partition count.
interface ebp_req_if import ebp_pkg::*; #(
  parameter int COORD_BITS = CoordBitsDef
) ();
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] start_i;
  logic signed [COORD_BITS-1:0] end_i;
  logic signed [COORD_BITS-1:0] start_j;
  logic signed [COORD_BITS-1:0] end_j;
  logic signed [COORD_BITS-1:0] start_k;
  logic signed [COORD_BITS-1:0] end_k;
  logic [CntInW-1:0]            part_count;

  modport source (
    output valid, start_i, end_i, start_j, end_j, start_k, end_k, part_count,
    input  ready
  );
  modport sink (
    input  valid, start_i, end_i, start_j, end_j, start_k, end_k, part_count,
    output ready
  );
endinterface

@@ rtl/core/ebp_rsp_if.sv @@
// Result channel: one partition extent per beat.
interface ebp_rsp_if import ebp_pkg::*; #(
  parameter int COORD_BITS = CoordBitsDef
) ();
  logic                         valid;
  logic                         ready;
  logic [PidxW-1:0]             part_index;
  logic signed [COORD_BITS-1:0] lo_i;
  logic signed [COORD_BITS-1:0] hi_i;
  logic signed [COORD_BITS-1:0] lo_j;
  logic signed [COORD_BITS-1:0] hi_j;
  logic signed [COORD_BITS-1:0] lo_k;
  logic signed [COORD_BITS-1:0] hi_k;
  logic                         last_part;

  modport source (
    output valid, part_index, lo_i, hi_i, lo_j, hi_j, lo_k, hi_k, last_part,
    input  ready
  );
  modport sink (
    input  valid, part_index, lo_i, hi_i, lo_j, hi_j, lo_k, hi_k, last_part,
    output ready
  );
endinterface

@@ rtl/core/extent_bisection_partitioner.sv @@
// Top level: microcoded recursive bisection of a 3-D index extent.
//
// channel | dir | handshake     | payload
// req_i   | in  | valid / ready | start/end per axis, part_count
// rsp_o   | out | valid / ready | part_index, lo/hi per axis, last_part
//
// Request with N partitions: an accept step, N-1 splits, a final check,
// then a table read and an output load per result beat.
// Split steps: queue read, table read, length, axis, then two writes on one port.
// Reset clears the sequencer, the counts and the output valid; tables need none.
// A stalled result holds the sequencer in its load step; a new request is
// taken while the final beat still waits in the output register.
module extent_bisection_partitioner import ebp_pkg::*; #(
  parameter int MAX_PARTS  = MaxPartsDef,
  parameter int COORD_BITS = CoordBitsDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  ebp_req_if.sink   req_i,
  ebp_rsp_if.source rsp_o
);

  localparam int IdxW = $clog2(MAX_PARTS);
  localparam int CntW = $clog2(MAX_PARTS + 1);
  localparam int LenW = COORD_BITS + 2;

  typedef logic [2:0][COORD_BITS-1:0] coord3_t;

  function automatic logic [IdxW-1:0] nxt_slot(input logic [IdxW-1:0] p);
    return (p == IdxW'(MAX_PARTS - 1)) ? '0 : p + 1'b1;
  endfunction

  coord3_t tbl_lo [MAX_PARTS];
  coord3_t tbl_hi [MAX_PARTS];
  logic [IdxW-1:0] queue_mem [MAX_PARTS];

  ebp_step_e       pc_q, pc_d;
  ebp_ucode_t      uc;
  logic            go, jmp;
  logic [CntW-1:0] count_q, want_q, want_d;
  logic [IdxW-1:0] head_q, tail_q, e_q, idx_q, qd_q;
  coord3_t         ent_lo_q, ent_hi_q, in_lo, in_hi;
  logic signed [LenW-1:0] len_q [3];
  logic signed [LenW-1:0] len_d [3];
  ebp_axis_t       axis_q, axis_d;
  logic signed [LenW-1:0] pt_sum;
  logic [COORD_BITS-1:0]  point;
  logic            wr_en, q_we, rd_en, slot_free, last_w;
  logic [IdxW-1:0] wr_addr, q_addr, q_data, rd_addr;
  coord3_t         wr_lo, wr_hi;
  logic            out_valid_q;
  logic [PidxW-1:0] out_idx_q;
  coord3_t         out_lo_q, out_hi_q;
  logic            out_last_q;

  assign uc        = ebp_ucode(pc_q);
  assign slot_free = !out_valid_q || rsp_o.ready;
  assign last_w    = (CntW'(e_q) + 1'b1) == count_q;

  always_comb begin
    case (uc.wt)
      WT_NONE: go = 1'b1;
      WT_REQ:  go = req_i.valid;
      WT_SLOT: go = slot_free;
      default: go = 1'b0;
    endcase
    case (uc.jc)
      JC_ALWAYS: jmp = 1'b1;
      JC_DONE:   jmp = count_q >= want_q;
      JC_LAST:   jmp = last_w;
      default:   jmp = 1'b1;
    endcase
    pc_d = go ? (jmp ? uc.tgt : uc.nxt) : pc_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= S_IDLE;
    end else begin
      pc_q <= pc_d;
    end
  end

  always_comb begin
    if (req_i.part_count == '0) begin
      want_d = CntW'(1);
    end else if (req_i.part_count > CntInW'(MAX_PARTS)) begin
      want_d = CntW'(MAX_PARTS);
    end else begin
      want_d = CntW'(req_i.part_count);
    end
  end

  assign in_lo = {req_i.start_k, req_i.start_j, req_i.start_i};
  assign in_hi = {req_i.end_k, req_i.end_j, req_i.end_i};

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      len_d[a] = LenW'($signed(ent_hi_q[a])) - LenW'($signed(ent_lo_q[a])) + LenW'(1);
    end
    if (len_q[0] >= len_q[1] && len_q[0] >= len_q[2]) begin
      axis_d = AX_I;
    end else if (len_q[1] >= len_q[2]) begin
      axis_d = AX_J;
    end else begin
      axis_d = AX_K;
    end
  end

  assign pt_sum = LenW'($signed(ent_lo_q[axis_q])) + (len_q[axis_q] >>> 1);
  assign point  = pt_sum[COORD_BITS-1:0];

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_lo   = ent_lo_q;
    wr_hi   = ent_hi_q;
    q_we    = 1'b0;
    q_addr  = tail_q;
    q_data  = idx_q;
    if (uc.ld_in && go) begin
      wr_en  = 1'b1;
      wr_lo  = in_lo;
      wr_hi  = in_hi;
      q_we   = 1'b1;
      q_addr = '0;
      q_data = '0;
    end else if (uc.wr_old) begin
      wr_en          = 1'b1;
      wr_addr        = idx_q;
      wr_hi[axis_q]  = point;
      q_we           = 1'b1;
    end else if (uc.wr_new) begin
      wr_en          = 1'b1;
      wr_addr        = count_q[IdxW-1:0];
      wr_lo[axis_q]  = point;
      q_we           = 1'b1;
      q_data         = count_q[IdxW-1:0];
    end
  end

  assign rd_en   = uc.rd_pop || uc.rd_emit;
  assign rd_addr = uc.rd_pop ? qd_q : e_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      tbl_lo[wr_addr] <= wr_lo;
      tbl_hi[wr_addr] <= wr_hi;
    end
    if (rd_en) begin
      ent_lo_q <= tbl_lo[rd_addr];
      ent_hi_q <= tbl_hi[rd_addr];
    end
    if (q_we) begin
      queue_mem[q_addr] <= q_data;
    end
    if (uc.q_rd) begin
      qd_q <= queue_mem[head_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (uc.rd_pop) begin
      idx_q <= qd_q;
    end
    if (uc.len_ld) begin
      len_q <= len_d;
    end
    if (uc.axis_ld) begin
      axis_q <= axis_d;
    end
    if (uc.out_ld && go) begin
      out_idx_q  <= PidxW'(e_q);
      out_lo_q   <= ent_lo_q;
      out_hi_q   <= ent_hi_q;
      out_last_q <= last_w;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      want_q      <= '0;
      head_q      <= '0;
      tail_q      <= '0;
      e_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (uc.ld_in && go) begin
        count_q <= CntW'(1);
        want_q  <= want_d;
        head_q  <= '0;
        tail_q  <= nxt_slot('0);
        e_q     <= '0;
      end
      if (uc.rd_pop) begin
        head_q <= nxt_slot(head_q);
      end
      if (uc.wr_old || uc.wr_new) begin
        tail_q <= nxt_slot(tail_q);
      end
      if (uc.wr_new) begin
        count_q <= count_q + 1'b1;
      end
      if (uc.out_ld && go) begin
        e_q         <= e_q + 1'b1;
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign req_i.ready      = uc.in_rdy;
  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.part_index = out_idx_q;
  assign rsp_o.lo_i       = out_lo_q[0];
  assign rsp_o.hi_i       = out_hi_q[0];
  assign rsp_o.lo_j       = out_lo_q[1];
  assign rsp_o.hi_j       = out_hi_q[1];
  assign rsp_o.lo_k       = out_lo_q[2];
  assign rsp_o.hi_k       = out_hi_q[2];
  assign rsp_o.last_part  = out_last_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MAX_PARTS))
    else $error("entry count beyond table depth");

  a_load_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> (count_q == CntW'(1) && pc_q == S_CHECK))
    else $error("request load did not seed the table");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pc_q == S_POP) |-> (head_q != tail_q))
    else $error("pop from empty work queue");

  a_emit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (uc.out_ld && go) |-> (CntW'(e_q) < count_q))
    else $error("emitted entry beyond table fill");

endmodule

@@ verif/tb_extent_bisection_partitioner.sv @@
`timescale 1ns / 1ps
// Testbench for the extent bisection partitioner: directed table and random requests.
module tb_extent_bisection_partitioner;
  import ebp_pkg::*;

  localparam int CW           = CoordBitsDef;
  localparam int MAXP         = MaxPartsDef;
  localparam int COORD_MAX    = 2 ** (CW - 1) - 1;
  localparam int COORD_MIN    = -(2 ** (CW - 1));
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int TAIL_CYCLES  = 24;
  localparam int RANDOM_ITEMS = 110;

  typedef logic signed [CW-1:0] coord_t;

  typedef struct packed {
    coord_t            start_i, end_i, start_j, end_j, start_k, end_k;
    logic [CntInW-1:0] part_count;
  } extent_req_t;

  typedef struct packed {
    logic [PidxW-1:0] part_index;
    coord_t           lo_i, hi_i, lo_j, hi_j, lo_k, hi_k;
    logic             last_part;
  } partition_t;

  typedef struct packed {
    extent_req_t req;
    logic [1:0]  n_typed;
    partition_t  typed0;
    partition_t  typed1;
  } stim_row_t;

  localparam partition_t NO_PART = '0;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  ebp_req_if #(.COORD_BITS(CW)) req_bus ();
  ebp_rsp_if #(.COORD_BITS(CW)) rsp_bus ();

  extent_bisection_partitioner #(
    .MAX_PARTS (MAXP),
    .COORD_BITS(CW)
  ) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_bus),
    .rsp_o (rsp_bus)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  int         part_lo    [MAXP][3];
  int         part_hi    [MAXP][3];
  int         split_fifo [MAXP];
  int         fifo_head;
  int         fifo_tail;
  int         part_total;
  partition_t pending_parts[$];
  stim_row_t  directed_rows[$];

  int mismatch_count = 0;
  int beats_checked  = 0;
  int requests_sent  = 0;
  int cycle_count    = 0;

  function automatic void queue_expected(partition_t p);
    pending_parts = {pending_parts, p};
  endfunction

  function automatic void add_row(stim_row_t s);
    directed_rows = {directed_rows, s};
  endfunction

  function automatic void bisect_request(extent_req_t r);
    int        want, idx, nw, len, point, li, lj, lk;
    ebp_axis_t ax;
    partition_t p;
    want = (r.part_count == 0) ? 1 : int'(r.part_count);
    if (want > MAXP) want = MAXP;
    part_lo[0][AX_I] = r.start_i;
    part_hi[0][AX_I] = r.end_i;
    part_lo[0][AX_J] = r.start_j;
    part_hi[0][AX_J] = r.end_j;
    part_lo[0][AX_K] = r.start_k;
    part_hi[0][AX_K] = r.end_k;
    fifo_head     = 0;
    split_fifo[0] = 0;
    fifo_tail     = 1;
    part_total    = 1;
    while (part_total < want) begin
      idx       = split_fifo[fifo_head];
      fifo_head = (fifo_head + 1) % MAXP;
      nw        = part_total;
      li = part_hi[idx][AX_I] - part_lo[idx][AX_I] + 1;
      lj = part_hi[idx][AX_J] - part_lo[idx][AX_J] + 1;
      lk = part_hi[idx][AX_K] - part_lo[idx][AX_K] + 1;
      if (li >= lj && li >= lk) begin
        ax = AX_I;
      end else if (lj >= lk) begin
        ax = AX_J;
      end else begin
        ax = AX_K;
      end
      len   = part_hi[idx][ax] - part_lo[idx][ax] + 1;
      point = part_lo[idx][ax] + (len >>> 1);
      for (int a = 0; a < 3; a++) begin
        part_lo[nw][a] = part_lo[idx][a];
        part_hi[nw][a] = part_hi[idx][a];
      end
      part_hi[idx][ax] = point;
      part_lo[nw][ax]  = point;
      part_total++;
      split_fifo[fifo_tail] = idx;
      fifo_tail             = (fifo_tail + 1) % MAXP;
      split_fifo[fifo_tail] = nw;
      fifo_tail             = (fifo_tail + 1) % MAXP;
    end
    for (int e = 0; e < part_total; e++) begin
      p.part_index = PidxW'(e);
      p.lo_i       = coord_t'(part_lo[e][AX_I]);
      p.hi_i       = coord_t'(part_hi[e][AX_I]);
      p.lo_j       = coord_t'(part_lo[e][AX_J]);
      p.hi_j       = coord_t'(part_hi[e][AX_J]);
      p.lo_k       = coord_t'(part_lo[e][AX_K]);
      p.hi_k       = coord_t'(part_hi[e][AX_K]);
      p.last_part  = (e == part_total - 1);
      queue_expected(p);
    end
  endfunction

  function automatic extent_req_t mk_req(input int si, ei, sj, ej, sk, ek, cnt);
    extent_req_t r;
    r.start_i    = coord_t'(si);
    r.end_i      = coord_t'(ei);
    r.start_j    = coord_t'(sj);
    r.end_j      = coord_t'(ej);
    r.start_k    = coord_t'(sk);
    r.end_k      = coord_t'(ek);
    r.part_count = CntInW'(cnt);
    return r;
  endfunction

  function automatic partition_t mk_part(input int pidx, ilo, ihi, jlo, jhi, klo, khi, lst);
    partition_t p;
    p.part_index = PidxW'(pidx);
    p.lo_i       = coord_t'(ilo);
    p.hi_i       = coord_t'(ihi);
    p.lo_j       = coord_t'(jlo);
    p.hi_j       = coord_t'(jhi);
    p.lo_k       = coord_t'(klo);
    p.hi_k       = coord_t'(khi);
    p.last_part  = lst[0];
    return p;
  endfunction

  function automatic stim_row_t row_of(extent_req_t rq, int n, partition_t t0, partition_t t1);
    stim_row_t s;
    s.req     = rq;
    s.n_typed = 2'(n);
    s.typed0  = t0;
    s.typed1  = t1;
    return s;
  endfunction

  function automatic extent_req_t random_request();
    extent_req_t r;
    int          lo [3];
    int          hi [3];
    int          pick, cnt;
    for (int a = 0; a < 3; a++) begin
      pick  = $urandom_range(0, 9);
      lo[a] = coord_t'($urandom);
      if (pick < 2) begin
        hi[a] = coord_t'($urandom);
      end else if (pick == 2) begin
        hi[a] = lo[a] - $urandom_range(1, 40);
      end else if (pick < 8) begin
        hi[a] = lo[a] + $urandom_range(0, 100);
      end else begin
        hi[a] = lo[a] + $urandom_range(0, 40000);
      end
      if (hi[a] > COORD_MAX) hi[a] = COORD_MAX;
      if (hi[a] < COORD_MIN) hi[a] = COORD_MIN;
    end
    pick = $urandom_range(0, 19);
    if (pick == 0) begin
      cnt = 0;
    end else if (pick == 1) begin
      cnt = $urandom_range(MAXP + 1, 2 ** CntInW - 1);
    end else if (pick < 4) begin
      cnt = $urandom_range(33, MAXP);
    end else begin
      cnt = $urandom_range(1, 16);
    end
    r = mk_req(lo[0], hi[0], lo[1], hi[1], lo[2], hi[2], cnt);
    return r;
  endfunction

  task automatic send_request(extent_req_t r);
    req_bus.valid      <= 1'b1;
    req_bus.start_i    <= r.start_i;
    req_bus.end_i      <= r.end_i;
    req_bus.start_j    <= r.start_j;
    req_bus.end_j      <= r.end_j;
    req_bus.start_k    <= r.start_k;
    req_bus.end_k      <= r.end_k;
    req_bus.part_count <= r.part_count;
    @(posedge clk_i);
    while (!req_bus.ready) @(posedge clk_i);
    requests_sent++;
  endtask

  task automatic hold_off(int cycles);
    if (cycles > 0) begin
      req_bus.valid <= 1'b0;
      repeat (cycles) @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    req_bus.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_parts.size() != 0) @(posedge clk_i);
  endtask

  function automatic int field_differs(string fld, int pidx, int exp_v, int act_v);
    if (exp_v == act_v) return 0;
    $display("%0t: part %0d %s mismatch, expected %0d, actual %0d",
             $time, pidx, fld, exp_v, act_v);
    return 1;
  endfunction

  logic [15:0] stall_mask = 16'hFFFF;
  int          stall_age  = 0;

  always @(posedge clk_i) begin
    if (stall_age == 0) begin
      case ($urandom_range(0, 3))
        0: begin
          stall_mask <= 16'hFFFF;
        end
        1: begin
          stall_mask <= 16'($urandom) | 16'h0001;
        end
        2: begin
          stall_mask <= 16'h8888;
        end
        default: begin
          stall_mask <= 16'($urandom) | 16'h8421;
        end
      endcase
    end else begin
      stall_mask <= {stall_mask[14:0], stall_mask[15]};
    end
    stall_age     <= (stall_age + 1) % 64;
    rsp_bus.ready <= stall_mask[0];
  end

  always @(posedge clk_i) begin : check_beats
    partition_t want;
    partition_t got;
    if (rst_ni && rsp_bus.valid && rsp_bus.ready) begin
      beats_checked++;
      got.part_index = rsp_bus.part_index;
      got.lo_i       = rsp_bus.lo_i;
      got.hi_i       = rsp_bus.hi_i;
      got.lo_j       = rsp_bus.lo_j;
      got.hi_j       = rsp_bus.hi_j;
      got.lo_k       = rsp_bus.lo_k;
      got.hi_k       = rsp_bus.hi_k;
      got.last_part  = rsp_bus.last_part;
      if (pending_parts.size() == 0) begin
        $display("%0t: unexpected beat, nothing pending, expected none, actual part %0d",
                 $time, got.part_index);
        mismatch_count++;
      end else begin
        want = pending_parts.pop_front();
        mismatch_count += field_differs("part_index", want.part_index, want.part_index,
                                        got.part_index);
        mismatch_count += field_differs("lo_i", want.part_index, want.lo_i, got.lo_i);
        mismatch_count += field_differs("hi_i", want.part_index, want.hi_i, got.hi_i);
        mismatch_count += field_differs("lo_j", want.part_index, want.lo_j, got.lo_j);
        mismatch_count += field_differs("hi_j", want.part_index, want.hi_j, got.hi_j);
        mismatch_count += field_differs("lo_k", want.part_index, want.lo_k, got.lo_k);
        mismatch_count += field_differs("hi_k", want.part_index, want.hi_k, got.hi_k);
        mismatch_count += field_differs("last_part", want.part_index, want.last_part,
                                        got.last_part);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: run exceeded %0d cycles, %0d beats still pending",
               $time, CYCLE_LIMIT, pending_parts.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    stim_row_t   row;
    extent_req_t r;
    int          burst_left;
    int          gap;
    req_bus.valid      = 1'b0;
    req_bus.start_i    = '0;
    req_bus.end_i      = '0;
    req_bus.start_j    = '0;
    req_bus.end_j      = '0;
    req_bus.start_k    = '0;
    req_bus.end_k      = '0;
    req_bus.part_count = '0;
    rsp_bus.ready      = 1'b0;

    add_row(row_of(mk_req(0, 0, 0, 0, 0, 0, 1), 1,
                   mk_part(0, 0, 0, 0, 0, 0, 0, 1), NO_PART));
    add_row(row_of(mk_req(COORD_MIN, COORD_MAX, 0, 0, 5, 9, 0), 1,
                   mk_part(0, COORD_MIN, COORD_MAX, 0, 0, 5, 9, 1),
                   NO_PART));
    add_row(row_of(mk_req(COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN,
                          COORD_MAX, COORD_MIN, 1), 1,
                   mk_part(0, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN,
                           COORD_MAX, COORD_MIN, 1), NO_PART));
    add_row(row_of(mk_req(0, 7, 0, 3, 0, 3, 2), 2,
                   mk_part(0, 0, 4, 0, 3, 0, 3, 0),
                   mk_part(1, 4, 7, 0, 3, 0, 3, 1)));
    add_row(row_of(mk_req(COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX,
                          COORD_MIN, COORD_MAX, 2), 2,
                   mk_part(0, COORD_MIN, 0, COORD_MIN, COORD_MAX,
                           COORD_MIN, COORD_MAX, 0),
                   mk_part(1, 0, COORD_MAX, COORD_MIN, COORD_MAX,
                           COORD_MIN, COORD_MAX, 1)));
    add_row(row_of(mk_req(10, 13, 20, 23, -4, -1, 3), 0, NO_PART, NO_PART));
    add_row(row_of(mk_req(0, 1, 0, 9, 0, 5, 2), 0, NO_PART, NO_PART));
    add_row(row_of(mk_req(0, 1, 0, 1, -100, 100, 2), 0, NO_PART, NO_PART));
    add_row(row_of(mk_req(0, 2, 0, 9, 0, 9, 2), 0, NO_PART, NO_PART));
    add_row(row_of(mk_req(COORD_MIN, COORD_MAX, -5, 5, 0, 1000, 127), 0,
                   NO_PART, NO_PART));
    add_row(row_of(mk_req(-5, 5, -5, 5, -5, 5, 65), 0, NO_PART, NO_PART));
    add_row(row_of(mk_req(7, 7, 7, 7, 7, 7, 64), 0, NO_PART, NO_PART));
    add_row(row_of(mk_req(100, 50, 0, 10, -20, -30, 3), 0, NO_PART, NO_PART));
    add_row(row_of(mk_req(5, 4, 6, 5, 7, 6, 4), 0, NO_PART, NO_PART));
    add_row(row_of(mk_req(-1000, -1, -30000, -29000, -5, -5, 5), 0,
                   NO_PART, NO_PART));
    add_row(row_of(mk_req(COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX,
                          COORD_MIN, COORD_MAX, 64), 0, NO_PART, NO_PART));
    add_row(row_of(mk_req(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN,
                          COORD_MIN, COORD_MIN, 3), 0, NO_PART, NO_PART));
    add_row(row_of(mk_req(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
                          COORD_MAX, COORD_MAX, 8), 0, NO_PART, NO_PART));
    add_row(row_of(mk_req(0, 255, 0, 127, 0, 63, 16), 0, NO_PART, NO_PART));
    add_row(row_of(mk_req(21845, -21846, -21846, 21845, 32512, 255, 33), 0,
                   NO_PART, NO_PART));

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[n]) begin
      row = directed_rows[n];
      send_request(row.req);
      if (row.n_typed == 0) begin
        bisect_request(row.req);
      end else begin
        queue_expected(row.typed0);
        if (row.n_typed == 2) queue_expected(row.typed1);
      end
      hold_off(($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 5));
    end

    // drain completely before the random part
    wait_drained();

    burst_left = 0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 2) begin
        wait_drained();
      end
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 8);
        case ($urandom_range(0, 5))
          0, 1: begin
            gap = 0;
          end
          2: begin
            gap = $urandom_range(20, 300);
          end
          default: begin
            gap = $urandom_range(1, 12);
          end
        endcase
        hold_off(gap);
      end
      r = random_request();
      send_request(r);
      bisect_request(r);
      burst_left--;
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Covered %0d requests (%0d directed, %0d random), %0d partition beats checked.",
             requests_sent, directed_rows.size(), RANDOM_ITEMS, beats_checked);
    $display("Field mismatches and stray beats: %0d, cycles used: %0d.",
             mismatch_count, cycle_count);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
